>>> hw/rtl/stepper_phase_sequencer_defines.svh
// Assertion macros for the checker file.
`ifndef STEPPER_PHASE_SEQUENCER_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/spsq_pkg.sv
`default_nettype none
package spsq_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int TIMER_BITS    = 18;
  localparam int INTERVAL_BITS = 18;

  // Step interval is USEC_PER_MINUTE / (factor * speed)
  localparam int USEC_PER_MINUTE = 60000000;
  localparam int DVD_BITS        = $clog2(USEC_PER_MINUTE + 1);
  localparam int DIV_CNT_BITS    = $clog2(DVD_BITS);
  localparam int HALF_FACTOR_I   = (15 * 4075) / 100;
  localparam int FULL_FACTOR_I   = (15 * 2037) / 100;
  localparam int FACTOR_BITS     = 10;
  localparam int SPEED_BITS      = 7;
  localparam int PROD_BITS       = FACTOR_BITS + SPEED_BITS;
  localparam int DIVISOR_BITS    = $clog2(HALF_FACTOR_I * 100 + 1);

  localparam logic [FACTOR_BITS-1:0] HALF_FACTOR = FACTOR_BITS'(HALF_FACTOR_I);
  localparam logic [FACTOR_BITS-1:0] FULL_FACTOR = FACTOR_BITS'(FULL_FACTOR_I);
  localparam logic [SPEED_BITS-1:0]  SPEED_MAX   = SPEED_BITS'(100);
  localparam logic [SPEED_BITS-1:0]  SPEED_MIN   = SPEED_BITS'(1);
  localparam logic [SPEED_BITS-1:0]  SPEED_RESET = SPEED_BITS'(100);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 7;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED     = 2'd2;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  localparam logic MODE_FULL = 1'b0;
  localparam logic MODE_HALF = 1'b1;
  localparam logic DIR_CW    = 1'b0;
  localparam logic DIR_CCW   = 1'b1;

  localparam logic [3:0] HALF_TABLE [8] = '{4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};
  localparam logic [3:0] FULL_TABLE [4] = '{4'd9, 4'd12, 4'd6, 4'd3};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } spsq_state_t;

  typedef struct packed {
    logic                    start;
    logic [DIVISOR_BITS-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [3:0] coil_lookup(input logic mode, input logic [2:0] ph);
    logic [3:0] lvl;
    if (mode == MODE_HALF) begin
      lvl = HALF_TABLE[ph];
    end else begin
      lvl = FULL_TABLE[ph[1:0]];
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/stepper_phase_sequencer.sv
// Stepper phase sequencer for a four-coil unipolar motor.
// Input stream: in_tuser is the request kind (0 one-microsecond tick,
// 1 start a move), in_tdata the step count of a start. Every input beat
// yields exactly one output beat: coil levels, busy flag and a flag that
// says whether this beat moved the phase.
// A tick's result beat is registered and valid in the cycle after its
// accept. A start computes the step interval with a restoring divider,
// one quotient bit per cycle over the 26-bit dividend; the start passes
// through ST_MUL and ST_DIV, its result beat is registered once the
// divider reports done, and in_tready stays low meanwhile.
// The output register frees the input side: a new beat is taken while a
// result waits, provided out_tready takes that result in the same cycle.
// A stalled receiver holds the output beat and holds in_tready low.
// Configuration (mode, direction, speed) is written on cfg_we; writes to unused indexes are ignored.
// The user writes it only while no move command is in flight; the block itself does not enforce this.
// Synchronous reset: coils off, no move, full-step, clockwise, speed 100.
`default_nettype none
module stepper_phase_sequencer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [15:0]                           in_tdata,   // step_count
  input  wire logic                                  in_tuser,   // req_type
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [7:0]                                 out_tdata,  // coil_pins, busy_res, stepped
  input  wire logic                                  cfg_we,
  input  wire logic [spsq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [spsq_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import spsq_pkg::*;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  spsq_state_t state_r, state_nxt;
  div_ctl_t    div_ctl;
  div_sts_t    div_sts;
  logic [INTERVAL_BITS-1:0] quotient;

  logic                     step_mode_r;
  logic                     direction_r;
  logic [SPEED_BITS-1:0]    speed_r;

  logic [2:0]               phase_r;
  logic [COUNT_BITS-1:0]    steps_left_r;
  logic [INTERVAL_BITS-1:0] interval_r;
  logic [TIMER_BITS-1:0]    elapsed_r;
  logic [3:0]               coil_r;

  logic                     out_valid_r;
  logic [3:0]               out_coil_r;
  logic                     out_busy_r;
  logic                     out_stepped_r;

  logic                     in_acc;
  logic                     tick_acc;
  logic                     start_acc;
  logic                     div_fin;
  logic                     moving;
  logic                     fire;
  logic [TIMER_BITS-1:0]    el_inc;
  logic [2:0]               phase_step;
  logic [COUNT_BITS-1:0]    steps_dec;
  logic [3:0]               coil_step;
  logic [FACTOR_BITS-1:0]   factor_w;
  logic [SPEED_BITS-1:0]    speed_w;
  logic [PROD_BITS-1:0]     prod_w;

  spsq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // Divisor: clamp speed into 1..100 and scale by the mode factor
  always_comb begin
    factor_w = (step_mode_r == MODE_HALF) ? HALF_FACTOR : FULL_FACTOR;
    if (speed_r > SPEED_MAX) begin
      speed_w = SPEED_MAX;
    end else if (speed_r == '0) begin
      speed_w = SPEED_MIN;
    end else begin
      speed_w = speed_r;
    end
    prod_w = PROD_BITS'(factor_w) * PROD_BITS'(speed_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    div_ctl.start   = 1'b0;
    div_ctl.divisor = prod_w[DIVISOR_BITS-1:0];
    case (state_r)
      ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (in_tvalid && in_tready && in_tuser == REQ_START) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        div_ctl.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_acc    = in_tvalid && in_tready;
  assign tick_acc  = in_acc && in_tuser == REQ_TICK;
  assign start_acc = in_acc && in_tuser == REQ_START;
  assign div_fin   = state_r == ST_DIV && div_sts.done;

  // Tick path: saturate the timer, step once the interval has elapsed
  always_comb begin
    moving     = steps_left_r != '0;
    el_inc     = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + 1'b1;
    fire       = moving && (el_inc >= TIMER_BITS'(interval_r));
    phase_step = (direction_r == DIR_CCW) ? phase_r - 3'd1 : phase_r + 3'd1;
    steps_dec  = steps_left_r - 1'b1;
    coil_step  = coil_lookup(step_mode_r, phase_step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_mode_r  <= MODE_FULL;
      direction_r  <= DIR_CW;
      speed_r      <= SPEED_RESET;
      phase_r      <= '0;
      steps_left_r <= '0;
      interval_r   <= '0;
      elapsed_r    <= '0;
      coil_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_MODE: step_mode_r <= cfg_wdata[0];
          CFG_DIRECTION: direction_r <= cfg_wdata[0];
          CFG_SPEED:     speed_r     <= cfg_wdata[SPEED_BITS-1:0];
          default: ;
        endcase
      end
      if (start_acc) begin
        steps_left_r <= COUNT_BITS'(in_tdata);
      end
      if (tick_acc && moving) begin
        if (fire) begin
          elapsed_r    <= '0;
          phase_r      <= phase_step;
          steps_left_r <= steps_dec;
          coil_r       <= coil_step;
        end else begin
          elapsed_r <= el_inc;
        end
      end
      if (div_fin) begin
        interval_r <= quotient;
        elapsed_r  <= TIMER_BITS'(quotient);
      end
      // Load a fresh result beat or drop the one just taken
      if (tick_acc || div_fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      out_coil_r    <= fire ? coil_step : coil_r;
      out_busy_r    <= fire ? (steps_dec != '0) : moving;
      out_stepped_r <= fire;
    end else if (div_fin) begin
      out_coil_r    <= coil_r;
      out_busy_r    <= moving;
      out_stepped_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_stepped_r, out_busy_r, out_coil_r};

endmodule
`default_nettype wire

>>> hw/rtl/spsq_div.sv
`default_nettype none
module spsq_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire spsq_pkg::div_ctl_t                   ctl,
  output spsq_pkg::div_sts_t                        sts,
  output logic [spsq_pkg::INTERVAL_BITS-1:0]        quotient
);
  import spsq_pkg::*;

  localparam logic [DIV_CNT_BITS-1:0] LAST_CNT = DIV_CNT_BITS'(DVD_BITS - 1);
  localparam logic [DVD_BITS-1:0]     DIVIDEND = DVD_BITS'(USEC_PER_MINUTE);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [DVD_BITS-1:0]     dvd_r, dvd_nxt;
  logic [DIVISOR_BITS-1:0] rem_r, rem_nxt;
  logic [DIVISOR_BITS-1:0] dsr_r, dsr_nxt;

  logic [DIVISOR_BITS:0]   rem_sh;
  logic [DIVISOR_BITS:0]   diff;
  logic                    fits;

  // One restoring shift-subtract step per cycle; quotient bits shift in
  // behind the dividend bits.
  always_comb begin
    rem_sh   = {rem_r, dvd_r[DVD_BITS-1]};
    fits     = rem_sh >= {1'b0, dsr_r};
    diff     = rem_sh - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = DIVIDEND;
      rem_nxt  = '0;
      dsr_nxt  = ctl.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
      dvd_nxt = {dvd_r[DVD_BITS-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r[INTERVAL_BITS-1:0];

endmodule
`default_nettype wire

>>> hw/rtl/spsq_checker.sv
`default_nettype none
`include "stepper_phase_sequencer_defines.svh"
module spsq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);
  import spsq_pkg::*;

  `SPSQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "output beat dropped while stalled")
  `SPSQ_ASSERT_NEXT(a_start_busy, in_tvalid && in_tready && in_tuser == REQ_START, !in_tready, "input taken during interval computation")
  `SPSQ_ASSERT_NEXT(a_tick_result, in_tvalid && in_tready && in_tuser == REQ_TICK, out_tvalid, "tick beat gave no result on the next cycle")
  `SPSQ_ASSERT_NOW(a_step_coils, out_tvalid && out_tdata[5], out_tdata[3:0] != 4'd0, "step reported with all coils off")

endmodule

bind stepper_phase_sequencer spsq_checker u_spsq_checker (.*);
`default_nettype wire
